### rtl/cft_pkg.sv
// Package for the CSV field tokenizer: word types, character codes,
// quote modes and queue sizing. No dependencies.
`default_nettype none

package cft_pkg;

	// Character codes
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] DELIM_RESET = 8'h2C;

	// Job queue between front and back (depth must be a power of two)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Quote tracking; code 3 never occurs and is handled as inside quotes
	typedef enum logic [1:0] {
		QM_OUT  = 2'd0,
		QM_IN   = 2'd1,
		QM_PEND = 2'd2
	} qmode_t;

	// Input word
	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_last;
	} item_t;

	// Result word
	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic       field_end;
		logic       record_end;
		logic       run_last;
	} result_t;

	// Classified byte: first result, plus an extra record-end result
	typedef struct packed {
		result_t first;
		logic    extra;
	} job_t;

	// Trailing empty field that closes a record
	localparam result_t RES_REC_END = '{
		has_char:   1'b0,
		out_char:   8'h00,
		field_end:  1'b1,
		record_end: 1'b1,
		run_last:   1'b1
	};

endpackage

`default_nettype wire

### rtl/csv_field_tokenizer.sv
// CSV field tokenizer: one byte per push; each byte's job is registered in a
// 4-entry job queue, and result words are read from the queue head.
// Throughput: one byte per cycle unless full; a byte that yields two words
// (delimiter as the last byte) holds the result side for two pops.
// Reset (arst_n low): outside quotes, record open, delimiter set to comma,
// queue empty. Config writes are always ready.
`default_nettype none

module csv_field_tokenizer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              push,
	output logic                   full,
	input  wire cft_pkg::item_t    item,
	output logic                   empty,
	input  wire logic              pop,
	output cft_pkg::result_t       result
);

	logic          job_push;
	cft_pkg::job_t job;
	logic          q_full, q_empty, q_pop;
	cft_pkg::job_t head;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// Classify incoming bytes
	cft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.job_push  (job_push),
		.job       (job)
	);

	// Decouple front and back
	cft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.data   (job),
		.full   (q_full),
		.pop    (q_pop),
		.head   (head),
		.empty  (q_empty)
	);

	// Emit result words
	cft_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

### rtl/cft_front.sv
// Front end of the CSV field tokenizer: accepts bytes, tracks quoting and
// record state, and turns each byte into at most one job. Uses cft_pkg.
`default_nettype none

module cft_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	input  wire logic [7:0]      cfg_data,
	input  wire logic            push,
	input  wire cft_pkg::item_t  item,
	input  wire logic            q_full,
	output logic                 job_push,
	output cft_pkg::job_t        job
);

	logic [7:0]      delim_q;
	cft_pkg::qmode_t qmode_q, qmode_n;
	logic            closed_q, closed_n;
	logic            accept;
	logic            is_quote, is_delim, is_crlf;
	logic            any, closed_now;
	logic [7:0]      b;

	assign accept   = push && !q_full;
	assign b        = item.in_byte;
	assign is_quote = (b == cft_pkg::CH_QUOTE);
	assign is_delim = (b == delim_q);
	assign is_crlf  = (b == cft_pkg::CH_CR) || (b == cft_pkg::CH_LF);

	// Delimiter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= cft_pkg::DELIM_RESET;
		end else if (cfg_valid) begin
			delim_q <= cfg_data;
		end
	end

	// Classify the byte and compute next quote and record state
	always_comb begin
		qmode_n    = qmode_q;
		closed_n   = closed_q;
		any        = 1'b0;
		closed_now = 1'b0;
		job        = '0;
		if (closed_q) begin
			if (item.line_last) begin
				closed_n = 1'b0;
				qmode_n  = cft_pkg::QM_OUT;
			end
		end else begin
			if (qmode_q == cft_pkg::QM_PEND && is_quote) begin
				// doubled quote: one literal quote
				any                = 1'b1;
				job.first.has_char = 1'b1;
				job.first.out_char = b;
				qmode_n            = cft_pkg::QM_IN;
			end else if (qmode_q == cft_pkg::QM_OUT || qmode_q == cft_pkg::QM_PEND) begin
				qmode_n = cft_pkg::QM_OUT;
				if (is_quote) begin
					qmode_n = cft_pkg::QM_IN;
				end else if (is_delim) begin
					any                 = 1'b1;
					job.first.field_end = 1'b1;
				end else if (is_crlf) begin
					any                  = 1'b1;
					job.first.field_end  = 1'b1;
					job.first.record_end = 1'b1;
					closed_now           = 1'b1;
				end else begin
					any                = 1'b1;
					job.first.has_char = 1'b1;
					job.first.out_char = b;
				end
			end else begin
				if (is_quote) begin
					qmode_n = cft_pkg::QM_PEND;
				end else begin
					any                = 1'b1;
					job.first.has_char = 1'b1;
					job.first.out_char = b;
				end
			end

			// Close the record on the line's last byte
			if (item.line_last) begin
				if (!closed_now) begin
					if (any && job.first.has_char) begin
						job.first.field_end  = 1'b1;
						job.first.record_end = 1'b1;
					end else if (any) begin
						job.extra = 1'b1;
					end else begin
						any                  = 1'b1;
						job.first.field_end  = 1'b1;
						job.first.record_end = 1'b1;
					end
				end
				qmode_n  = cft_pkg::QM_OUT;
				closed_n = 1'b0;
			end else if (closed_now) begin
				closed_n = 1'b1;
				qmode_n  = cft_pkg::QM_OUT;
			end
		end
		job.first.run_last = !job.extra;
	end

	assign job_push = accept && any;

	// Advance state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qmode_q  <= cft_pkg::QM_OUT;
			closed_q <= 1'b0;
		end else if (accept) begin
			qmode_q  <= qmode_n;
			closed_q <= closed_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_closed_unquoted: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> (qmode_q == cft_pkg::QM_OUT))
		else $error("record closed while quote mode is active");
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> !job_push)
		else $error("job pushed after record was closed");
`endif

endmodule

`default_nettype wire

### rtl/cft_queue.sv
// Short job queue between the front and back of the CSV field tokenizer,
// held in flip-flops. Uses cft_pkg.
`default_nettype none

module cft_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cft_pkg::job_t  data,
	output logic                full,
	input  wire logic           pop,
	output cft_pkg::job_t       head,
	output logic                empty
);

	cft_pkg::job_t                mem_q [cft_pkg::QDEPTH];
	logic [cft_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [cft_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push, do_pop;

	assign full    = (count_q == cft_pkg::QCNT_W'(cft_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Store words
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cft_pkg::QCNT_W'(cft_pkg::QDEPTH))
		else $error("queue count above depth");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after push");
`endif

endmodule

`default_nettype wire

### rtl/cft_back.sv
// Back end of the CSV field tokenizer: expands each queued job into one or
// two result words and drives the result side. Uses cft_pkg.
`default_nettype none

module cft_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cft_pkg::job_t   head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output cft_pkg::result_t     result,
	output logic                 empty,
	input  wire logic            pop
);

	logic idx_q;
	logic take;

	assign empty  = q_empty;
	assign take   = pop && !q_empty;
	assign result = idx_q ? cft_pkg::RES_REC_END : head.first;
	assign q_pop  = take && (!head.extra || idx_q);

	// Step to the extra word, or back to the first word of the next job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (take) begin
			idx_q <= head.extra && !idx_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_extra_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (!q_empty && head.extra))
		else $error("second word selected without a two-word job");
`endif

endmodule

`default_nettype wire

### test/csv_field_tokenizer_tb.sv
// Testbench for csv_field_tokenizer: drives bytes of CSV lines and delimiter
// writes, predicts every result word and checks each one as it is popped.
// Depends on cft_pkg and the csv_field_tokenizer RTL only.

module csv_field_tokenizer_tb;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 155;
	localparam int NUM_PHASES   = 9;

	// Token prediction and result checking
	class token_checker;
		cft_pkg::result_t expected_words[$];
		logic [7:0]       delim;
		cft_pkg::qmode_t  qmode;
		bit               closed;
		int               errors;

		function new();
			delim  = cft_pkg::DELIM_RESET;
			qmode  = cft_pkg::QM_OUT;
			closed = 1'b0;
			errors = 0;
		endfunction

		function cft_pkg::result_t make_word(bit has, logic [7:0] ch, bit fe, bit re);
			cft_pkg::result_t w;
			w.has_char   = has;
			w.out_char   = has ? ch : 8'h00;
			w.field_end  = fe;
			w.record_end = re;
			w.run_last   = 1'b0;
			return w;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// Work out the words one accepted byte causes
		function void note_byte(cft_pkg::item_t it);
			cft_pkg::result_t words[$];
			bit               ends_rec;
			bit               taken;
			ends_rec = 1'b0;
			taken    = 1'b0;
			// Drop bytes after CR/LF until the line's last byte
			if (closed) begin
				if (it.line_last) begin
					closed = 1'b0;
					qmode  = cft_pkg::QM_OUT;
				end
				return;
			end
			// Resolve a pending quote: doubled quote or leave quotes
			if (qmode == cft_pkg::QM_PEND) begin
				if (it.in_byte == cft_pkg::CH_QUOTE) begin
					words = {words, make_word(1'b1, cft_pkg::CH_QUOTE, 1'b0, 1'b0)};
					qmode = cft_pkg::QM_IN;
					taken = 1'b1;
				end else begin
					qmode = cft_pkg::QM_OUT;
				end
			end
			if (!taken) begin
				if (qmode == cft_pkg::QM_OUT) begin
					if (it.in_byte == cft_pkg::CH_QUOTE)
						qmode = cft_pkg::QM_IN;
					else if (it.in_byte == delim)
						words = {words, make_word(1'b0, 8'h00, 1'b1, 1'b0)};
					else if (it.in_byte == cft_pkg::CH_CR ||
							it.in_byte == cft_pkg::CH_LF) begin
						words = {words, make_word(1'b0, 8'h00, 1'b1, 1'b1)};
						ends_rec = 1'b1;
					end else
						words = {words, make_word(1'b1, it.in_byte, 1'b0, 1'b0)};
				end else begin
					if (it.in_byte == cft_pkg::CH_QUOTE)
						qmode = cft_pkg::QM_PEND;
					else
						words = {words, make_word(1'b1, it.in_byte, 1'b0, 1'b0)};
				end
			end
			// Close the record on the line's last byte
			if (it.line_last) begin
				if (!ends_rec) begin
					if (words.size() > 0 && words[words.size()-1].has_char &&
							!words[words.size()-1].field_end) begin
						words[words.size()-1].field_end  = 1'b1;
						words[words.size()-1].record_end = 1'b1;
					end else begin
						words = {words, make_word(1'b0, 8'h00, 1'b1, 1'b1)};
					end
				end
				qmode  = cft_pkg::QM_OUT;
				closed = 1'b0;
			end else if (ends_rec) begin
				closed = 1'b1;
				qmode  = cft_pkg::QM_OUT;
			end
			// Mark the last word of this byte
			if (words.size() > 0)
				words[words.size()-1].run_last = 1'b1;
			expected_words = {expected_words, words};
		endfunction

		// Compare one popped word with the oldest expectation
		function void check_word(cft_pkg::result_t got);
			cft_pkg::result_t exp;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: has=%b ch=%h fe=%b re=%b rl=%b",
						got.has_char, got.out_char, got.field_end,
						got.record_end, got.run_last);
				return;
			end
			exp = expected_words.pop_front();
			if (got.has_char !== exp.has_char || got.out_char !== exp.out_char ||
					got.field_end !== exp.field_end ||
					got.record_end !== exp.record_end ||
					got.run_last !== exp.run_last) begin
				errors++;
				if (errors <= 10)
					$display(
						"mismatch exp %b %h %b %b %b got %b %h %b %b %b",
						exp.has_char, exp.out_char, exp.field_end, exp.record_end,
						exp.run_last, got.has_char, got.out_char, got.field_end,
						got.record_end, got.run_last);
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [7:0]       cfg_data  = 8'h00;
	logic             push      = 1'b0;
	cft_pkg::item_t   item      = '0;
	logic             pop       = 1'b0;
	logic             cfg_ready;
	logic             full;
	logic             empty;
	cft_pkg::result_t result;

	token_checker board = new();
	int cycles      = 0;
	int rx_hold_left = 0;
	bit steady      = 1'b0;

	csv_field_tokenizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	always #6 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("csv_field_tokenizer verification failed");
			$finish;
		end
	end

	// Idle length: mostly none or short, a few long
	function int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one byte and wait for the word to be accepted
	task send_byte(logic [7:0] b, bit last);
		int g;
		g = (steady || rx_hold_left > 0) ? 0 : idle_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item <= '{in_byte: b, line_last: last};
		push <= 1'b1;
		do @(posedge clk); while (full);
		board.note_byte(cft_pkg::item_t'{in_byte: b, line_last: last});
	endtask

	// Byte biased toward the characters that steer the parser
	function logic [7:0] pick_byte(logic [7:0] d);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return cft_pkg::CH_QUOTE;
		else if (r < 28)
			return d;
		else if (r < 32)
			return $urandom_range(0, 1) ? cft_pkg::CH_CR : cft_pkg::CH_LF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Send one line with random content, or a noise byte now and then
	task send_line(logic [7:0] d, inout int cnt);
		int len;
		if ($urandom_range(0, 9) == 0) begin
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			cnt++;
			return;
		end
		len = ($urandom_range(0, 19) == 0) ? 30 : $urandom_range(1, 10);
		for (int i = 0; i < len; i++) begin
			send_byte(pick_byte(d), i == len - 1);
			cnt++;
		end
	endtask

	// Wait for the block to drain, then write the delimiter
	task write_delim(logic [7:0] v);
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.delim = v;
	endtask

	// Pop result words with random stalls and two long hold-offs
	initial begin
		int g;
		int rx_stall;
		rx_stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_word(result);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				pop <= 1'b0;
			end else if (steady) begin
				pop <= 1'b1;
			end else begin
				g = idle_len();
				if (g == 0)
					pop <= 1'b1;
				else begin
					rx_stall = g - 1;
					pop <= 1'b0;
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [7:0] delims [NUM_PHASES];
		int cnt;
		delims = '{8'h2C, 8'h00, 8'hFF, cft_pkg::CH_QUOTE, cft_pkg::CH_CR,
			cft_pkg::CH_LF, 8'h09, 8'h3B, 8'h00};
		delims[NUM_PHASES-1] = 8'($urandom_range(0, 255));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed line: extremes, quotes, doubled quote, CR in quotes, delimiter last
		send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(",", 1'b0);
		send_byte(cft_pkg::CH_QUOTE, 1'b0); send_byte("x", 1'b0);
		send_byte(cft_pkg::CH_QUOTE, 1'b0); send_byte(cft_pkg::CH_QUOTE, 1'b0);
		send_byte(cft_pkg::CH_CR, 1'b0); send_byte(cft_pkg::CH_QUOTE, 1'b0);
		send_byte("b", 1'b0); send_byte(",", 1'b1);
		// Line ends on a pending quote
		send_byte(cft_pkg::CH_QUOTE, 1'b0); send_byte("q", 1'b0);
		send_byte(cft_pkg::CH_QUOTE, 1'b1);
		// Opening quote as the only byte
		send_byte(cft_pkg::CH_QUOTE, 1'b1);
		// Line ends inside quotes on a char
		send_byte(cft_pkg::CH_QUOTE, 1'b0); send_byte("w", 1'b1);
		// LF closes the record, the rest is dropped
		send_byte("z", 1'b0); send_byte(cft_pkg::CH_LF, 1'b0); send_byte("k", 1'b0);
		send_byte(",", 1'b0); send_byte(cft_pkg::CH_QUOTE, 1'b0);
		send_byte(cft_pkg::CH_CR, 1'b1);
		// Char as the only byte
		send_byte(8'h7E, 1'b1);

		// Random phases, one delimiter each
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_delim(delims[p]);
			steady = (p == 1) || ($urandom_range(0, 3) == 0);
			if (p == 2 || p == 6)
				rx_hold_left = HOLD_CYCLES;
			cnt = 0;
			while (cnt < PHASE_ITEMS)
				send_line(delims[p], cnt);
		end
		steady = 1'b0;

		// Drain and finish
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("csv_field_tokenizer verification clean");
		else
			$display("csv_field_tokenizer verification failed");
		$finish;
	end

endmodule
